// ----- design/fcl_pkg.sv -----
// Shared types and constants of the FAT32 cluster chain locator.
// No dependencies; the module files import this package, the interface files do not.
package fcl_pkg;

    localparam int FAT_ENTRIES  = 4096;
    localparam int IDX_W        = $clog2(FAT_ENTRIES);
    localparam int SECTOR_BYTES = 512;
    localparam int BYTE_W       = $clog2(SECTOR_BYTES);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_LOCATE = 2'd1;
    localparam logic [1:0] REQ_NEXT   = 2'd2;

    localparam logic [27:0] CHAIN_END_MIN = 28'hFFFFFF8;

    localparam logic [0:0] REG_FDS = 1'b0;
    localparam logic [0:0] REG_SPC = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_END = 2'd1,
        ST_OUT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_LOCATE,
        OP_NEXT,
        OP_ZERO,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       data;
        logic [BYTE_W-1:0] byte_pos;
        logic [31:0]       sector;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_WRD,
        S_WDAT,
        S_LRD,
        S_LDAT,
        S_NRD,
        S_NDAT,
        S_EMIT
    } state_t;

endpackage

// ----- design/fcl_req_if.sv -----
// Request channel of the chain locator: valid/ready plus request fields.
// Depends on nothing.
interface fcl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] cluster_index;
    logic [31:0] entry_value;
    logic [31:0] byte_offset;
    logic [31:0] sector_in;

    modport source (output valid, req_type, cluster_index, entry_value, byte_offset,
                    sector_in, input ready);
    modport sink (input valid, req_type, cluster_index, entry_value, byte_offset,
                  sector_in, output ready);
endinterface

// ----- design/fcl_res_if.sv -----
// Result channel of the chain locator: valid/ready plus result fields.
// Depends on nothing.
interface fcl_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] sector_out;
    logic [8:0]  byte_in_sector;
    logic [1:0]  status;

    modport source (output valid, sector_out, byte_in_sector, status, input ready);
    modport sink (input valid, sector_out, byte_in_sector, status, output ready);
endinterface

// ----- design/fat32_cluster_chain_locator_unit.sv -----
// FAT32 cluster chain locator: table load, locate and next-sector requests.
// Throughput is one item at a time, set by the bit-serial divider and the
// single table read port. Reset clears control and the config registers; the
// table is not cleared and holds garbage until written.
module fat32_cluster_chain_locator_unit
    import fcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fcl_req_if.sink     req,
    fcl_res_if.source   res
);

    // Configuration registers. Software must write them only while idle; the block
    // does not enforce it. The front and back end use them freely during a request.
    logic [31:0] fds_reg;
    logic [7:0]  spc_reg;
    logic [7:0]  spc_eff;
    logic        cfg_wr;

    logic        cmd_valid;
    cmd_t        cmd;
    logic        pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fds_reg <= 32'd0;
            spc_reg <= 8'd8;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FDS: fds_reg <= pwdata;
                REG_SPC: spc_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FDS: prdata = fds_reg;
            REG_SPC: prdata = {24'd0, spc_reg};
            default: prdata = 32'd0;
        endcase
    end

    // A cluster size of zero behaves as one sector.
    assign spc_eff = (spc_reg == 8'd0) ? 8'd1 : spc_reg;

    // The front end classifies each beat and queues it in a two-entry queue,
    // so a new request is taken while the back end is still busy.
    fcl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req.valid),
        .in_ready      (req.ready),
        .req_type      (req.req_type),
        .cluster_index (req.cluster_index),
        .entry_value   (req.entry_value),
        .byte_offset   (req.byte_offset),
        .sector_in     (req.sector_in),
        .fds           (fds_reg),
        .pop           (pop),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    // The back end owns the table memory, the divider and the result register.
    fcl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .pop            (pop),
        .fds            (fds_reg),
        .spc            (spc_eff),
        .res_valid      (res.valid),
        .res_ready      (res.ready),
        .sector_out     (res.sector_out),
        .byte_in_sector (res.byte_in_sector),
        .status         (res.status)
    );

endmodule

// ----- design/fcl_front.sv -----
// Front end: classifies incoming requests and queues them for the back end.
// Depends on fcl_pkg.
module fcl_front
    import fcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] cluster_index,
    input  logic [31:0] entry_value,
    input  logic [31:0] byte_offset,
    input  logic [31:0] sector_in,
    input  logic [31:0] fds,
    input  logic        pop,
    output logic        cmd_valid,
    output cmd_t        cmd
);

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       push;

    // Classification: bad start clusters and sectors ahead of the data area
    // are flagged here, so the back end answers them without a table read.
    always_comb
    begin
        cls          = '0;
        cls.op       = OP_ZERO;
        cls.idx      = cluster_index;
        cls.byte_pos = byte_offset[BYTE_W-1:0];
        cls.sector   = sector_in;
        unique case (req_type)
            REQ_WRITE:
            begin
                cls.op   = OP_WRITE;
                cls.data = entry_value;
            end
            REQ_LOCATE:
            begin
                cls.op   = (cluster_index < IDX_W'(2)) ? OP_BAD : OP_LOCATE;
                cls.data = 32'(byte_offset >> BYTE_W);
            end
            REQ_NEXT:
            begin
                cls.op   = (sector_in < fds) ? OP_BAD : OP_NEXT;
                cls.data = sector_in - fds;
            end
            default:
            begin
                cls.op = OP_ZERO;
            end
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

endmodule

// ----- design/fcl_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on fcl_pkg.
module fcl_div
    import fcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [CNT_W-1:0] remainder
);

    logic [31:0]      quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = CNT_W'(trial);
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/fcl_back.sv -----
// Back end: holds the allocation table, walks chains and forms results.
// Depends on fcl_pkg and fcl_div.
module fcl_back
    import fcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        pop,
    input  logic [31:0] fds,
    input  logic [7:0]  spc,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] sector_out,
    output logic [8:0]  byte_in_sector,
    output logic [1:0]  status
);

    logic [31:0]       fat_mem [FAT_ENTRIES];
    logic [31:0]       rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  lstart_reg, lstart_next;
    logic [31:0]       n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [7:0]        srem_reg, srem_next;
    logic              loop_reg, loop_next;
    logic              rv_reg, rv_next;
    logic [31:0]       rsec_reg, rsec_next;
    logic [8:0]        rbyte_reg, rbyte_next;
    status_t           rst_reg, rst_next;
    logic [31:0]       esec_next;
    logic [8:0]        ebyte_next;
    status_t           est_next;
    logic [31:0]       esec_reg;
    logic [8:0]        ebyte_reg;
    status_t           est_reg;

    logic              div_start;
    logic [31:0]       div_a;
    logic [CNT_W-1:0]  div_b;
    logic              div_done;
    logic [31:0]       div_q;
    logic [CNT_W-1:0]  div_r;

    logic [27:0]       ent;
    logic              ent_end;
    logic              ent_bad;
    logic [19:0]       base_off;
    logic [IDX_W-1:0]  base_c;

    fcl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign ent     = rd_data_reg[27:0];
    assign ent_end = (ent >= CHAIN_END_MIN);
    assign ent_bad = (ent < 28'd2) || (ent[27:IDX_W] != '0);

    // Sector offset of a cluster relative to the first data sector.
    assign base_off = 20'(base_c - IDX_W'(2)) * 20'(spc);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cur_next    = cur_reg;
        lstart_next = lstart_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        srem_next   = srem_reg;
        loop_next   = loop_reg;
        rv_next     = rv_reg;
        rsec_next   = rsec_reg;
        rbyte_next  = rbyte_reg;
        rst_next    = rst_reg;
        esec_next   = esec_reg;
        ebyte_next  = ebyte_reg;
        est_next    = est_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        wr_en       = 1'b0;
        div_start   = 1'b0;
        div_a       = cmd.data;
        div_b       = CNT_W'(spc);
        base_c      = cur_reg;

        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = cmd;
                    esec_next  = '0;
                    ebyte_next = '0;
                    est_next   = ST_OK;
                    loop_next  = 1'b0;
                    cur_next   = cmd.idx;
                    unique case (cmd.op)
                        OP_WRITE:
                        begin
                            wr_en      = 1'b1;
                            state_next = S_EMIT;
                        end
                        OP_LOCATE, OP_NEXT:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        OP_BAD:
                        begin
                            est_next   = ST_OUT;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (loop_reg)
                    begin
                        n_next     = 32'(div_r);
                        cnt_next   = '0;
                        state_next = S_WRD;
                    end
                    else if (cmd_reg.op == OP_LOCATE)
                    begin
                        n_next     = div_q;
                        srem_next  = div_r[7:0];
                        cnt_next   = '0;
                        state_next = S_WRD;
                    end
                    else if (div_q >= 32'(FAT_ENTRIES - 2))
                    begin
                        est_next   = ST_OUT;
                        state_next = S_EMIT;
                    end
                    else if (div_r != CNT_W'(spc) - CNT_W'(1))
                    begin
                        esec_next  = cmd_reg.sector + 32'd1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cur_next   = div_q[IDX_W-1:0] + IDX_W'(2);
                        state_next = S_NRD;
                    end
                end
            end
            S_WRD:
            begin
                base_c = cur_reg;
                if (32'(cnt_reg) == n_reg)
                begin
                    esec_next  = fds + 32'(base_off) + 32'(srem_reg);
                    ebyte_next = 9'(cmd_reg.byte_pos);
                    state_next = S_EMIT;
                end
                else if (cnt_reg == CNT_W'(FAT_ENTRIES))
                begin
                    // Every link so far was good, so the chain closes on a loop.
                    lstart_next = cur_reg;
                    len_next    = '0;
                    state_next  = S_LRD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_WDAT;
                end
            end
            S_WDAT:
            begin
                if (ent_end)
                begin
                    est_next   = ST_END;
                    state_next = S_EMIT;
                end
                else if (ent_bad)
                begin
                    est_next   = ST_OUT;
                    state_next = S_EMIT;
                end
                else
                begin
                    cur_next   = ent[IDX_W-1:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_WRD;
                end
            end
            S_LRD:
            begin
                rd_en      = 1'b1;
                state_next = S_LDAT;
            end
            S_LDAT:
            begin
                cur_next = ent[IDX_W-1:0];
                len_next = len_reg + CNT_W'(1);
                if (ent[IDX_W-1:0] == lstart_reg)
                begin
                    div_start  = 1'b1;
                    div_a      = n_reg - 32'(cnt_reg);
                    div_b      = len_reg + CNT_W'(1);
                    loop_next  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_LRD;
                end
            end
            S_NRD:
            begin
                rd_en      = 1'b1;
                state_next = S_NDAT;
            end
            S_NDAT:
            begin
                base_c = ent[IDX_W-1:0];
                if (ent_end)
                begin
                    est_next = ST_END;
                end
                else if (ent_bad)
                begin
                    est_next = ST_OUT;
                end
                else
                begin
                    esec_next = fds + 32'(base_off);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rv_reg || res_ready)
                begin
                    rv_next    = 1'b1;
                    rsec_next  = esec_reg;
                    rbyte_next = ebyte_reg;
                    rst_next   = est_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            loop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            loop_reg  <= loop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        lstart_reg <= lstart_next;
        n_reg      <= n_next;
        cnt_reg    <= cnt_next;
        len_reg    <= len_next;
        srem_reg   <= srem_next;
        rsec_reg   <= rsec_next;
        rbyte_reg  <= rbyte_next;
        rst_reg    <= rst_next;
        esec_reg   <= esec_next;
        ebyte_reg  <= ebyte_next;
        est_reg    <= est_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fat_mem[cmd.idx] <= cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= fat_mem[rd_addr];
        end
    end

    assign res_valid      = rv_reg;
    assign sector_out     = rsec_reg;
    assign byte_in_sector = rbyte_reg;
    assign status         = rst_reg;

endmodule

// ----- tb/fat32_cluster_chain_locator_unit_tb.sv -----
// Self-checking testbench for the FAT32 cluster chain locator unit.
// Depends on fcl_pkg, fcl_req_if, fcl_res_if and the unit itself.
module fat32_cluster_chain_locator_unit_tb;
    import fcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    RUN_LIMIT     = 100_000_000;
    localparam int    ITEMS_PER_SET = 200;
    localparam int    NUM_SETS      = 6;
    localparam int    SETTLE_CYCLES = 50;
    localparam int    USED_CLUSTERS = 256;

    // One expected beat on the result channel.
    typedef struct {
        logic [31:0] sector;
        logic [8:0]  byte_pos;
        status_t     status;
    } chain_answer_t;

    // Mirror of the unit: its FAT copy, its registers and the answers still owed.
    class chain_scoreboard;
        logic [31:0]   fat_copy [FAT_ENTRIES];
        logic [31:0]   fds;
        logic [7:0]    spc;
        chain_answer_t owed_q [$];
        int            errors;

        function new();
            fds    = 32'd0;
            spc    = 8'd8;
            errors = 0;
        endfunction

        function logic [31:0] spc_used();
            return (spc == 8'd0) ? 32'd1 : {24'd0, spc};
        endfunction

        function logic [31:0] cluster_start(input logic [31:0] c);
            return fds + (c - 32'd2) * spc_used();
        endfunction

        // Follows one table link out of cluster c.
        function status_t hop(input logic [11:0] c, output logic [11:0] nx);
            logic [27:0] e;
            e  = fat_copy[c][27:0];
            nx = c;
            if (e >= CHAIN_END_MIN)
                return ST_END;
            if (e < 28'd2 || e >= FAT_ENTRIES)
                return ST_OUT;
            nx = e[11:0];
            return ST_OK;
        endfunction

        // Walks n links; a long walk must be circling a loop, so the rest of the
        // count is reduced modulo the loop length.
        function status_t walk_chain(inout logic [11:0] c, input longint unsigned n);
            longint unsigned done;
            longint unsigned loop_len;
            logic [11:0]     cur;
            logic [11:0]     anchor;
            status_t         st;
            done = 0;
            cur  = c;
            while (done < n && done < FAT_ENTRIES) begin
                st = hop(cur, cur);
                if (st != ST_OK)
                    return st;
                done++;
            end
            if (done < n) begin
                anchor   = cur;
                loop_len = 0;
                do begin
                    st = hop(cur, cur);
                    loop_len++;
                end while (cur != anchor);
                n = (n - done) % loop_len;
                while (n > 0) begin
                    st = hop(cur, cur);
                    n--;
                end
            end
            c = cur;
            return ST_OK;
        endfunction

        // Notes one accepted request and queues the answer it must produce.
        function void note_request(input logic [1:0] kind, input logic [11:0] idx,
                                   input logic [31:0] value, input logic [31:0] off,
                                   input logic [31:0] sin);
            chain_answer_t a;
            logic [31:0]   csize;
            logic [31:0]   rem;
            logic [31:0]   rel;
            logic [63:0]   cl;
            logic [11:0]   c;
            logic [11:0]   nx;
            a.sector   = 32'd0;
            a.byte_pos = 9'd0;
            a.status   = ST_OK;
            case (kind)
                REQ_WRITE:
                    fat_copy[idx] = value;
                REQ_LOCATE:
                    if (idx < 12'd2) begin
                        a.status = ST_OUT;
                    end
                    else begin
                        csize    = spc_used() * SECTOR_BYTES;
                        rem      = off % csize;
                        c        = idx;
                        a.status = walk_chain(c, longint'(off / csize));
                        if (a.status == ST_OK) begin
                            a.sector   = cluster_start({20'd0, c}) + rem / SECTOR_BYTES;
                            a.byte_pos = rem[8:0];
                        end
                    end
                REQ_NEXT:
                    if (sin < fds) begin
                        a.status = ST_OUT;
                    end
                    else begin
                        rel = sin - fds;
                        cl  = {32'd0, rel / spc_used()} + 64'd2;
                        if (cl >= FAT_ENTRIES)
                            a.status = ST_OUT;
                        else if (rel % spc_used() != spc_used() - 32'd1)
                            a.sector = sin + 32'd1;
                        else begin
                            a.status = hop(cl[11:0], nx);
                            if (a.status == ST_OK)
                                a.sector = cluster_start({20'd0, nx});
                        end
                    end
                default: ;
            endcase
            if (a.status != ST_OK) begin
                a.sector   = 32'd0;
                a.byte_pos = 9'd0;
            end
            owed_q.push_back(a);
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got %h expected %h", what, got, want);
        endtask

        // Compares one result beat against the oldest answer owed.
        task check_result(input logic [31:0] sector, input logic [8:0] byte_pos,
                          input logic [1:0] status);
            chain_answer_t a;
            if (owed_q.size() == 0) begin
                report("unexpected result beat", sector, 32'd0);
            end
            else begin
                a = owed_q.pop_front();
                if (status !== a.status)
                    report("status", {30'd0, status}, {30'd0, a.status});
                if (sector !== a.sector)
                    report("sector_out", sector, a.sector);
                if (byte_pos !== a.byte_pos)
                    report("byte_in_sector", {23'd0, byte_pos}, {23'd0, a.byte_pos});
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fcl_req_if req ();
    fcl_res_if res ();

    fat32_cluster_chain_locator_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req.sink),
        .res     (res.source)
    );

    chain_scoreboard sb = new();
    int              snd_idle_pct;
    int              rcv_idle_pct;
    int              cycles;

    // 8 ns clock period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: a hung handshake or a runaway walk ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls at random according to the current idling mode.
    always @(posedge clk)
    begin
        res.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Both channels are observed at the clock edge, so every value read here is
    // the one that was present when the beat was taken.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.req_type, req.cluster_index, req.entry_value,
                            req.byte_offset, req.sector_in);
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.sector_out, res.byte_in_sector, res.status);
    end

    // Register write over the APB-style port: setup cycle, then access cycle.
    task reg_write(input logic [0:0] which, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_FDS)
            sb.fds = value;
        else
            sb.spc = value[7:0];
    endtask

    // Presents one request beat and holds it until the unit takes it. A gap,
    // when drawn, drops valid first; otherwise valid simply stays high.
    task send_request(input logic [1:0] kind, input logic [11:0] idx,
                      input logic [31:0] value, input logic [31:0] off,
                      input logic [31:0] sin);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < snd_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= kind;
        req.cluster_index <= idx;
        req.entry_value   <= value;
        req.byte_offset   <= off;
        req.sector_in     <= sin;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Waits until every owed answer has arrived, then lets the unit settle.
    task drain();
        req.valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random table word. Most entries link to the next cluster so that chains
    // are long; the rest end the chain, jump anywhere in the used clusters
    // (which builds loops) or hold an illegal link. Legal links never leave the
    // used clusters, so every walk stays on loaded entries. The top nibble is
    // always random and must be masked.
    function logic [31:0] table_word(input int idx);
        int          pick;
        logic [27:0] link;
        pick = $urandom_range(0, 99);
        if (pick < 60 && idx < USED_CLUSTERS - 1)
            link = 28'(idx + 1);
        else if (pick < 80)
            link = 28'hFFFFFF8 + 28'($urandom_range(0, 7));
        else if (pick < 92)
            link = 28'($urandom_range(2, USED_CLUSTERS - 1));
        else if (pick < 96)
            link = 28'($urandom_range(0, 1));
        else
            link = 28'($urandom_range(FAT_ENTRIES, 32'h0FFFFFF7));
        return {4'($urandom_range(0, 15)), link};
    endfunction

    // Sector inside the data area: usually the last sector of a cluster, so that
    // the request has to cross into the next cluster through the table.
    function logic [31:0] data_sector();
        logic [31:0] s;
        logic [31:0] c;
        s = sb.spc_used();
        c = $urandom_range(2, USED_CLUSTERS - 1);
        if ($urandom_range(0, 1) == 0)
            return sb.cluster_start(c) + s - 32'd1;
        return sb.cluster_start(c) + $urandom_range(0, s - 1);
    endfunction

    // Sector whose cluster lies beyond the table.
    function logic [31:0] far_sector();
        logic [31:0] s;
        logic [31:0] c;
        s = sb.spc_used();
        c = $urandom_range(FAT_ENTRIES, FAT_ENTRIES + 32'h0010_0000);
        return sb.cluster_start(c) + $urandom_range(0, s - 1);
    endfunction

    task random_request();
        int          pick;
        logic [31:0] csize;
        logic [31:0] off;
        logic [31:0] sin;
        pick  = $urandom_range(0, 99);
        csize = sb.spc_used() * SECTOR_BYTES;
        if (pick < 15) begin
            off = $urandom_range(0, USED_CLUSTERS - 1);
            send_request(REQ_WRITE, off[11:0], table_word(off), $urandom(), $urandom());
        end
        else if (pick < 60) begin
            // Offsets mostly span a handful of clusters; some are arbitrary
            // 32-bit values, which run into chain ends or circle loops.
            if ($urandom_range(0, 99) < 75)
                off = $urandom_range(0, 6 * csize);
            else
                off = $urandom();
            send_request(REQ_LOCATE,
                         ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 1))
                                                      : 12'($urandom_range(2,
                                                            USED_CLUSTERS - 1)),
                         $urandom(), off, $urandom());
        end
        else if (pick < 95) begin
            sin = ($urandom_range(0, 99) < 75) ? data_sector() : far_sector();
            send_request(REQ_NEXT, 12'($urandom()), $urandom(), $urandom(), sin);
        end
        else begin
            send_request(2'd3, 12'($urandom()), $urandom(), $urandom(), $urandom());
        end
    endtask

    // Hand-picked requests under the reset settings (first data sector 0,
    // eight sectors per cluster, 4 KiB clusters).
    task directed_requests();
        send_request(REQ_WRITE, 12'd2, 32'hF000_0003, 32'd0, 32'd0);
        send_request(REQ_WRITE, 12'd3, 32'h0FFF_FFFF, 32'd0, 32'd0);
        send_request(REQ_WRITE, 12'd5, 32'hFFFF_FFF1, 32'd0, 32'd0);
        send_request(REQ_WRITE, 12'd6, 32'h0000_0007, 32'd0, 32'd0);
        send_request(REQ_WRITE, 12'd7, 32'hA000_0006, 32'd0, 32'd0);
        send_request(REQ_WRITE, 12'd8, 32'h0000_1000, 32'd0, 32'd0);
        send_request(REQ_WRITE, 12'd4095, 32'hFFFF_FFF8, 32'd0, 32'd0);
        // Start clusters outside the data area.
        send_request(REQ_LOCATE, 12'd0, 32'd0, 32'd0, 32'd0);
        send_request(REQ_LOCATE, 12'd1, 32'd0, 32'hFFFF_FFFF, 32'd0);
        // Inside the first cluster, one link, then past the end mark.
        send_request(REQ_LOCATE, 12'd2, 32'd0, 32'd4095, 32'd0);
        send_request(REQ_LOCATE, 12'd2, 32'd0, 32'd4096 + 32'd777, 32'd0);
        send_request(REQ_LOCATE, 12'd2, 32'd0, 32'd8192, 32'd0);
        // A link of 0xFFFFFF1 and a link to cluster 4096, both beyond the table, are illegal.
        send_request(REQ_LOCATE, 12'd5, 32'd0, 32'd4096, 32'd0);
        send_request(REQ_LOCATE, 12'd8, 32'd0, 32'd4096, 32'd0);
        // Two-cluster loop walked for the largest possible offset.
        send_request(REQ_LOCATE, 12'd6, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_LOCATE, 12'd4095, 32'd0, 32'd511, 32'd0);
        // Next sector inside a cluster, across clusters, at an end mark, at an illegal
        // link, and for a sector whose cluster lies beyond the table.
        send_request(REQ_NEXT, 12'd0, 32'd0, 32'd0, 32'd0);
        send_request(REQ_NEXT, 12'd0, 32'd0, 32'd0, 32'd7);
        send_request(REQ_NEXT, 12'd0, 32'd0, 32'd0, 32'd15);
        send_request(REQ_NEXT, 12'd0, 32'd0, 32'd0, 32'd55);
        send_request(REQ_NEXT, 12'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(2'd3, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    initial
    begin
        logic [31:0] set_fds [NUM_SETS];
        logic [7:0]  set_spc [NUM_SETS];
        set_fds = '{32'd0, 32'd1000, 32'hFFFF_FF00, 32'd12345, 32'hFFFF_FFFF, 32'd7};
        set_spc = '{8'd8, 8'd1, 8'd128, 8'd0, 8'd255, 8'd3};
        cycles        = 0;
        snd_idle_pct  = 37;
        rcv_idle_pct  = 74;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        req.valid         = 1'b0;
        req.req_type      = REQ_WRITE;
        req.cluster_index = 12'd0;
        req.entry_value   = 32'd0;
        req.byte_offset   = 32'd0;
        req.sector_in     = 32'd0;
        res.ready         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every cluster that a request can reach before any walk reads it.
        for (int i = 0; i < USED_CLUSTERS; i++)
            send_request(REQ_WRITE, 12'(i), table_word(i), 32'd0, 32'd0);
        directed_requests();

        for (int s = 0; s < NUM_SETS; s++) begin
            // Idling mode: receiver-heavy, then sender-heavy, then none.
            if (s < 2) begin
                snd_idle_pct = 37;
                rcv_idle_pct = 74;
            end
            else if (s < 4) begin
                snd_idle_pct = 74;
                rcv_idle_pct = 37;
            end
            else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            // The unit is drained before every register change; the sender
            // holds off until all owed answers are back.
            if (s > 0) begin
                drain();
                reg_write(REG_FDS, set_fds[s]);
                reg_write(REG_SPC, {24'd0, set_spc[s]});
            end
            for (int n = 0; n < ITEMS_PER_SET; n++)
                random_request();
        end

        drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
